// File: src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// shared types and widths for the triangle circumsphere core
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int SQ_W       = PROD_W;
   localparam int CC_W       = 2 * CROSS_W;
   localparam int TP_W       = CROSS_W + DIFF_W;
   localparam int TRIPLE_W   = TP_W + 1;
   localparam int SPLIT      = 26;
   localparam int HI_W       = TRIPLE_W - SPLIT;
   localparam int PP_W       = HI_W + SQ_W + 1;
   localparam int DEN_W      = CC_W + 1;
   localparam int NUM_W      = 88;
   localparam int QUO_W      = 32;
   localparam int OUT_W      = 32;
   localparam int RAD_W      = 68;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int LIMIT_W    = 40;
   localparam int DIV_DEPTH  = QUO_W + 1;
   localparam int SQRT_DEPTH = ROOT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd4295;

   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   typedef logic [2:0][COORD_W-1:0] coord3_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] center_x;
      logic signed [OUT_W-1:0] center_y;
      logic signed [OUT_W-1:0] center_z;
      logic [OUT_W-1:0]        radius;
      logic                    collinear;
      logic                    clipped;
   } rsp_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0] mag;
      logic [2:0]            neg;
      logic [DEN_W-1:0]      den;
      logic                  coll;
      coord3_type            p1;
      coord3_type            mid;
      logic [SQ_W-1:0]       bb;
   } geom_type;

   typedef struct packed {
      logic            coll;
      logic [2:0]      neg;
      coord3_type      p1;
      coord3_type      mid;
      logic [SQ_W-1:0] bb;
   } side1_type;

   typedef struct packed {
      logic                  coll;
      logic                  clip;
      logic                  huge;
      logic [2:0][OUT_W-1:0] center;
   } side2_type;

endpackage

`default_nettype wire

// File: src/tcs_delay.sv
// ----------------------------------------------------------------------------
// tcs_delay
// stallable delay line that keeps side data aligned with a long unit
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] in_data,
   output logic      [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int s = 1; s < DEPTH; s++) begin
            data_ff[s] <= data_ff[s-1];
         end
      end
   end

   assign out_data = data_ff[DEPTH-1];

endmodule

`default_nettype wire

// File: src/tcs_geom.sv
// ----------------------------------------------------------------------------
// tcs_geom
// edge vectors, cross products, collinear test and center numerators
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_geom (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire tcs_pkg::req_type              in_data,
   input  wire logic [tcs_pkg::LIMIT_W-1:0]   limit,
   output logic                               out_valid,
   output tcs_pkg::geom_type                  out_data
);

   import tcs_pkg::*;

   logic signed [COORD_W-1:0] p1_c [3];
   logic signed [COORD_W-1:0] p2_c [3];
   logic signed [COORD_W-1:0] p3_c [3];
   logic [DIFF_W-1:0]         msum_c [3];
   logic [DIFF_W-1:0]         mrnd_c [3];

   logic [9:1] v_ff;

   logic signed [DIFF_W-1:0]   a1_ff [3], b1_ff [3], a2_ff [3], b2_ff [3], a3_ff [3], b3_ff [3];
   logic signed [PROD_W-1:0]   abp0_ff [3], abp1_ff [3], asq_ff [3], bsq_ff [3];
   logic signed [CROSS_W-1:0]  c3_ff [3];
   logic signed [CC_W-1:0]     cc4_ff [3];
   logic signed [TP_W-1:0]     ca0_ff [3], ca1_ff [3], bc0_ff [3], bc1_ff [3];
   logic signed [TRIPLE_W-1:0] cxa5_ff [3], bxc5_ff [3];
   logic signed [PP_W-1:0]     phc6_ff [3], plc6_ff [3], phb6_ff [3], plb6_ff [3];
   logic signed [NUM_W-1:0]    sc7_ff [3], sb7_ff [3], num8_ff [3];
   logic [NUM_W-1:0]           mag9_ff [3];
   logic [2:0]                 neg9_ff;
   logic [SQ_W-1:0]            aa_ff [3:5];
   logic [SQ_W-1:0]            bb_ff [3:9];
   logic [DEN_W-1:0]           den_ff [5:9];
   logic                       coll_ff [6:9];
   coord3_type                 p1_ff [1:9];
   coord3_type                 mid_ff [1:9];

   always_comb begin
      p1_c[0] = in_data.first_x;
      p1_c[1] = in_data.first_y;
      p1_c[2] = in_data.first_z;
      p2_c[0] = in_data.second_x;
      p2_c[1] = in_data.second_y;
      p2_c[2] = in_data.second_z;
      p3_c[0] = in_data.third_x;
      p3_c[1] = in_data.third_y;
      p3_c[2] = in_data.third_z;
      for (int i = 0; i < 3; i++) begin
         msum_c[i] = {p1_c[i][COORD_W-1], p1_c[i]} + {p3_c[i][COORD_W-1], p3_c[i]};
         mrnd_c[i] = msum_c[i] + {{(DIFF_W-1){1'b0}}, msum_c[i][DIFF_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[8:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // edge vectors and midpoint
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]     <= {p2_c[i][COORD_W-1], p2_c[i]} - {p1_c[i][COORD_W-1], p1_c[i]};
            b1_ff[i]     <= {p3_c[i][COORD_W-1], p3_c[i]} - {p1_c[i][COORD_W-1], p1_c[i]};
            p1_ff[1][i]  <= p1_c[i];
            mid_ff[1][i] <= mrnd_c[i][DIFF_W-1:1];
         end
         // cross and square products
         for (int i = 0; i < 3; i++) begin
            abp0_ff[i] <= a1_ff[NXT[i]] * b1_ff[PRV[i]];
            abp1_ff[i] <= a1_ff[PRV[i]] * b1_ff[NXT[i]];
            asq_ff[i]  <= a1_ff[i] * a1_ff[i];
            bsq_ff[i]  <= b1_ff[i] * b1_ff[i];
            a2_ff[i]   <= a1_ff[i];
            b2_ff[i]   <= b1_ff[i];
         end
         // cross vector and squared lengths
         for (int i = 0; i < 3; i++) begin
            c3_ff[i] <= {abp0_ff[i][PROD_W-1], abp0_ff[i]} - {abp1_ff[i][PROD_W-1], abp1_ff[i]};
            a3_ff[i] <= a2_ff[i];
            b3_ff[i] <= b2_ff[i];
         end
         aa_ff[3] <= $unsigned(asq_ff[0]) + $unsigned(asq_ff[1]) + $unsigned(asq_ff[2]);
         bb_ff[3] <= $unsigned(bsq_ff[0]) + $unsigned(bsq_ff[1]) + $unsigned(bsq_ff[2]);
         // second cross products
         for (int i = 0; i < 3; i++) begin
            cc4_ff[i] <= c3_ff[i] * c3_ff[i];
            ca0_ff[i] <= c3_ff[NXT[i]] * a3_ff[PRV[i]];
            ca1_ff[i] <= c3_ff[PRV[i]] * a3_ff[NXT[i]];
            bc0_ff[i] <= b3_ff[NXT[i]] * c3_ff[PRV[i]];
            bc1_ff[i] <= b3_ff[PRV[i]] * c3_ff[NXT[i]];
         end
         aa_ff[4] <= aa_ff[3];
         // denominator and numerator directions
         den_ff[5] <= ({1'b0, cc4_ff[0]} + {1'b0, cc4_ff[1]} + {1'b0, cc4_ff[2]}) << 1;
         for (int i = 0; i < 3; i++) begin
            cxa5_ff[i] <= {ca0_ff[i][TP_W-1], ca0_ff[i]} - {ca1_ff[i][TP_W-1], ca1_ff[i]};
            bxc5_ff[i] <= {bc0_ff[i][TP_W-1], bc0_ff[i]} - {bc1_ff[i][TP_W-1], bc1_ff[i]};
         end
         aa_ff[5] <= aa_ff[4];
         // collinear test and split products
         coll_ff[6] <= (den_ff[5] == '0) ||
                       (den_ff[5] < {{(DEN_W-LIMIT_W){1'b0}}, limit});
         for (int i = 0; i < 3; i++) begin
            phc6_ff[i] <= $signed(cxa5_ff[i][TRIPLE_W-1:SPLIT]) * $signed({1'b0, bb_ff[5]});
            plc6_ff[i] <= $signed({1'b0, cxa5_ff[i][SPLIT-1:0]}) * $signed({1'b0, bb_ff[5]});
            phb6_ff[i] <= $signed(bxc5_ff[i][TRIPLE_W-1:SPLIT]) * $signed({1'b0, aa_ff[5]});
            plb6_ff[i] <= $signed({1'b0, bxc5_ff[i][SPLIT-1:0]}) * $signed({1'b0, aa_ff[5]});
         end
         // recombine split products
         for (int i = 0; i < 3; i++) begin
            sc7_ff[i] <= (NUM_W'(phc6_ff[i]) <<< SPLIT) + NUM_W'(plc6_ff[i]);
            sb7_ff[i] <= (NUM_W'(phb6_ff[i]) <<< SPLIT) + NUM_W'(plb6_ff[i]);
         end
         for (int i = 0; i < 3; i++) begin
            num8_ff[i] <= sc7_ff[i] + sb7_ff[i];
         end
         // sign and magnitude
         for (int i = 0; i < 3; i++) begin
            neg9_ff[i] <= num8_ff[i][NUM_W-1];
            mag9_ff[i] <= num8_ff[i][NUM_W-1] ? $unsigned(-num8_ff[i]) : $unsigned(num8_ff[i]);
         end
         // side data
         for (int s = 2; s <= 9; s++) begin
            p1_ff[s]  <= p1_ff[s-1];
            mid_ff[s] <= mid_ff[s-1];
         end
         for (int s = 4; s <= 9; s++) begin
            bb_ff[s] <= bb_ff[s-1];
         end
         for (int s = 6; s <= 9; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 7; s <= 9; s++) begin
            coll_ff[s] <= coll_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_data.mag[i] = mag9_ff[i];
      end
      out_data.neg  = neg9_ff;
      out_data.den  = den_ff[9];
      out_data.coll = coll_ff[9];
      out_data.p1   = p1_ff[9];
      out_data.mid  = mid_ff[9];
      out_data.bb   = bb_ff[9];
   end

   assign out_valid = v_ff[9];

endmodule

`default_nettype wire

// File: src/tcs_div.sv
// ----------------------------------------------------------------------------
// tcs_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_div (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [tcs_pkg::NUM_W-1:0]   num,
   input  wire logic [tcs_pkg::DEN_W-1:0]   den,
   output logic      [tcs_pkg::QUO_W-1:0]   quo,
   output logic                             huge
);

   import tcs_pkg::*;

   logic [DEN_W-1:0] rem_ff  [DIV_DEPTH];
   logic [DEN_W-1:0] den_ff  [DIV_DEPTH];
   logic [QUO_W-1:0] nlo_ff  [DIV_DEPTH];
   logic [QUO_W-1:0] quo_ff  [DIV_DEPTH];
   logic             huge_ff [DIV_DEPTH];

   logic [DEN_W:0] trial_c [DIV_DEPTH];
   logic           ge_c    [DIV_DEPTH];

   always_comb begin
      trial_c[0] = '0;
      ge_c[0]    = 1'b0;
      for (int k = 1; k < DIV_DEPTH; k++) begin
         trial_c[k] = {rem_ff[k-1], nlo_ff[k-1][QUO_W-k]};
         ge_c[k]    = trial_c[k] >= {1'b0, den_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // quotient of 2^32 or more means overflow
         huge_ff[0] <= {{(DEN_W+QUO_W-NUM_W){1'b0}}, num} >= {den, {QUO_W{1'b0}}};
         rem_ff[0]  <= {{(DEN_W-NUM_W+QUO_W){1'b0}}, num[NUM_W-1:QUO_W]};
         nlo_ff[0]  <= num[QUO_W-1:0];
         den_ff[0]  <= den;
         quo_ff[0]  <= '0;
         for (int k = 1; k < DIV_DEPTH; k++) begin
            rem_ff[k]  <= ge_c[k] ? DEN_W'(trial_c[k] - {1'b0, den_ff[k-1]})
                                  : trial_c[k][DEN_W-1:0];
            quo_ff[k]  <= {quo_ff[k-1][QUO_W-2:0], ge_c[k]};
            nlo_ff[k]  <= nlo_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            huge_ff[k] <= huge_ff[k-1];
         end
      end
   end

   assign quo  = quo_ff[DIV_DEPTH-1];
   assign huge = huge_ff[DIV_DEPTH-1];

endmodule

`default_nettype wire

// File: src/tcs_sqrt.sv
// ----------------------------------------------------------------------------
// tcs_sqrt
// pipelined digit-by-digit floor square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_sqrt (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [tcs_pkg::RAD_W-1:0]    rad,
   output logic      [tcs_pkg::ROOT_W-1:0]   root
);

   import tcs_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]  rem_ff  [SQRT_DEPTH];
   logic [ROOT_W-1:0] root_ff [SQRT_DEPTH];
   logic [RAD_W-1:0]  rad_ff  [SQRT_DEPTH];

   logic [REM_W+1:0]  cur_c   [SQRT_DEPTH];
   logic [REM_W+1:0]  trial_c [SQRT_DEPTH];
   logic              ge_c    [SQRT_DEPTH];
   logic [REM_W-1:0]  prem_c  [SQRT_DEPTH];
   logic [ROOT_W-1:0] proot_c [SQRT_DEPTH];
   logic [RAD_W-1:0]  prad_c  [SQRT_DEPTH];

   always_comb begin
      for (int k = 0; k < SQRT_DEPTH; k++) begin
         if (k == 0) begin
            prem_c[k]  = '0;
            proot_c[k] = '0;
            prad_c[k]  = rad;
         end else begin
            prem_c[k]  = rem_ff[k-1];
            proot_c[k] = root_ff[k-1];
            prad_c[k]  = rad_ff[k-1];
         end
         cur_c[k]   = {prem_c[k], prad_c[k][RAD_W-1:RAD_W-2]};
         trial_c[k] = {2'b00, proot_c[k], 2'b01};
         ge_c[k]    = cur_c[k] >= trial_c[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_DEPTH; k++) begin
            rem_ff[k]  <= ge_c[k] ? REM_W'(cur_c[k] - trial_c[k]) : cur_c[k][REM_W-1:0];
            root_ff[k] <= {proot_c[k][ROOT_W-2:0], ge_c[k]};
            rad_ff[k]  <= {prad_c[k][RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_DEPTH-1];

endmodule

`default_nettype wire

// File: src/triangle_circumsphere_core.sv
// ----------------------------------------------------------------------------
// triangle_circumsphere_core
// circumcenter and radius of three 3d points, with collinear fallback
// ----------------------------------------------------------------------------
// datapath: geometry stages, the 33-stage divider, offset and saturation registers,
// the 34-stage square root, then the result register; throughput one word per cycle
// a stalled result word freezes the whole pipeline until it is taken
// reset clears all valid bits and sets collinear_limit to 4295
`default_nettype none

module triangle_circumsphere_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tcs_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tcs_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_write_enable,
   input  wire logic [tcs_pkg::LIMIT_W-1:0]   csr_write_data
);

   import tcs_pkg::*;

   localparam int S1_W = $bits(side1_type);
   localparam int S2_W = $bits(side2_type);

   logic [LIMIT_W-1:0] limit_ff;
   logic               en;

   logic     g_valid;
   geom_type g_data;

   logic [QUO_W-1:0] quo_c [3];
   logic [2:0]       huge_c;
   side1_type        s1_in, s1_out;
   logic [DIV_DEPTH-1:0] dv_ff;

   logic signed [QUO_W:0]   dq_c [3];
   logic [OUT_W+1:0]        dsum_ff [3];
   logic [2*QUO_W-1:0]      qsq_ff [3];
   logic [2:0]              huge1_ff, neg1_ff;
   logic                    coll1_ff, t1_valid_ff;
   coord3_type              mid1_ff;
   logic [SQ_W-1:0]         bb1_ff;

   logic [RAD_W-1:0] rad_ff;
   side2_type        s2_ff, s2_out, s2_c;
   logic             t2_valid_ff;
   logic [SQRT_DEPTH-1:0] sv_ff;
   logic [ROOT_W-1:0]     root_c;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_c;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   tcs_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .limit     (limit_ff),
      .out_valid (g_valid),
      .out_data  (g_data)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      tcs_div u_div (
         .clock (clock),
         .en    (en),
         .num   (g_data.mag[i]),
         .den   (g_data.den),
         .quo   (quo_c[i]),
         .huge  (huge_c[i])
      );
   end

   always_comb begin
      s1_in.coll = g_data.coll;
      s1_in.neg  = g_data.neg;
      s1_in.p1   = g_data.p1;
      s1_in.mid  = g_data.mid;
      s1_in.bb   = g_data.bb;
   end

   tcs_delay #(.WIDTH(S1_W), .DEPTH(DIV_DEPTH)) u_side1 (
      .clock    (clock),
      .en       (en),
      .in_data  (s1_in),
      .out_data (s1_out)
   );

   // offset, center sum and squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dq_c[i] = s1_out.neg[i] ? -$signed({1'b0, quo_c[i]}) : $signed({1'b0, quo_c[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dsum_ff[i] <= {{(OUT_W+2-COORD_W){s1_out.p1[i][COORD_W-1]}}, s1_out.p1[i]} +
                          {dq_c[i][QUO_W], dq_c[i]};
            qsq_ff[i]  <= quo_c[i] * quo_c[i];
         end
         huge1_ff <= huge_c;
         neg1_ff  <= s1_out.neg;
         coll1_ff <= s1_out.coll;
         mid1_ff  <= s1_out.mid;
         bb1_ff   <= s1_out.bb;
      end
   end

   // saturation and radicand select
   always_comb begin
      s2_c.coll = coll1_ff;
      s2_c.huge = |huge1_ff;
      s2_c.clip = |huge1_ff;
      for (int i = 0; i < 3; i++) begin
         if (coll1_ff) begin
            s2_c.center[i] = {{(OUT_W-COORD_W){mid1_ff[i][COORD_W-1]}}, mid1_ff[i]};
         end else if (huge1_ff[i]) begin
            s2_c.center[i] = neg1_ff[i] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
         end else if (dsum_ff[i][OUT_W+1:OUT_W-1] == 3'b000 ||
                      dsum_ff[i][OUT_W+1:OUT_W-1] == 3'b111) begin
            s2_c.center[i] = dsum_ff[i][OUT_W-1:0];
         end else begin
            s2_c.clip      = 1'b1;
            s2_c.center[i] = dsum_ff[i][OUT_W+1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                 : {1'b0, {(OUT_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff  <= s2_c;
         rad_ff <= coll1_ff ? {{(RAD_W-SQ_W){1'b0}}, bb1_ff}
                            : {{(RAD_W-2*QUO_W){1'b0}}, qsq_ff[0]} +
                              {{(RAD_W-2*QUO_W){1'b0}}, qsq_ff[1]} +
                              {{(RAD_W-2*QUO_W){1'b0}}, qsq_ff[2]};
      end
   end

   tcs_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root_c)
   );

   tcs_delay #(.WIDTH(S2_W), .DEPTH(SQRT_DEPTH)) u_side2 (
      .clock    (clock),
      .en       (en),
      .in_data  (s2_ff),
      .out_data (s2_out)
   );

   always_comb begin
      rsp_c.center_x  = s2_out.center[0];
      rsp_c.center_y  = s2_out.center[1];
      rsp_c.center_z  = s2_out.center[2];
      rsp_c.collinear = s2_out.coll;
      if (s2_out.coll) begin
         rsp_c.radius  = root_c[OUT_W:1];
         rsp_c.clipped = 1'b0;
      end else if (s2_out.huge || root_c[ROOT_W-1:OUT_W] != '0) begin
         rsp_c.radius  = '1;
         rsp_c.clipped = 1'b1;
      end else begin
         rsp_c.radius  = root_c[OUT_W-1:0];
         rsp_c.clipped = s2_out.clip;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= '0;
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         sv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         dv_ff        <= {dv_ff[DIV_DEPTH-2:0], g_valid};
         t1_valid_ff  <= dv_ff[DIV_DEPTH-1];
         t2_valid_ff  <= t1_valid_ff;
         sv_ff        <= {sv_ff[SQRT_DEPTH-2:0], t2_valid_ff};
         rsp_valid_ff <= sv_ff[SQRT_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_coll_noclip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.collinear |-> !rsp_data_ff.clipped)
      else $error("collinear word flagged as clipped");

   a_coll_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.collinear |-> rsp_data_ff.radius[OUT_W-1:SQ_W/2] == '0)
      else $error("collinear radius out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !t1_valid_ff && !t2_valid_ff)
      else $error("valid bits survive reset");

endmodule

`default_nettype wire

// File: dv/circumsphere_checker.sv
// ----------------------------------------------------------------------------
// circumsphere_checker
// watches the request and response channels of the triangle circumsphere
// core, works out the sphere for every accepted request word with its own
// wide-integer arithmetic and compares every response word field by field
// ----------------------------------------------------------------------------
`default_nettype none

module circumsphere_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire tcs_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire tcs_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_write_enable,
   input  wire logic [tcs_pkg::LIMIT_W-1:0]   csr_write_data,
   output int                                 failures,
   output int                                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import tcs_pkg::*;

   localparam int DUE_DEPTH = 256;

   logic [LIMIT_W-1:0] limit;
   rsp_type            due_mem [DUE_DEPTH];
   int                 wr_count;
   int                 rd_count;

   function automatic logic [63:0] floor_root(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int n = 33; n >= 0; n--) begin
         t = r | (64'd1 << n);
         if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   function automatic rsp_type sphere_of(req_type w, logic [LIMIT_W-1:0] lim);
      longint            p1[3], p2[3], p3[3];
      logic signed [127:0] aw[3], bw[3], cw[3];
      logic signed [127:0] den, aa, bb, cxa, bxc, num, d;
      logic [127:0]      denu, mag, q, r2;
      logic [63:0]       root;
      logic [31:0]       cen[3];
      longint            sum;
      bit                coll, clip, huge;
      int                j, k;
      rsp_type           o;
      p1 = '{w.first_x, w.first_y, w.first_z};
      p2 = '{w.second_x, w.second_y, w.second_z};
      p3 = '{w.third_x, w.third_y, w.third_z};
      aa = 0;
      bb = 0;
      for (int i = 0; i < 3; i++) begin
         aw[i] = p2[i] - p1[i];
         bw[i] = p3[i] - p1[i];
         aa = aa + aw[i] * aw[i];
         bb = bb + bw[i] * bw[i];
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         cw[i] = aw[j] * bw[k] - aw[k] * bw[j];
      end
      den = 2 * (cw[0] * cw[0] + cw[1] * cw[1] + cw[2] * cw[2]);
      denu = den;
      coll = (denu == 0) || (lim != 0 && denu < {88'd0, lim});
      clip = 0;
      huge = 0;
      if (coll) begin
         for (int i = 0; i < 3; i++) begin
            sum = (p1[i] + p3[i]) / 2;
            cen[i] = sum[31:0];
         end
         root = floor_root(bb) >> 1;
      end else begin
         r2 = '0;
         for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            cxa = cw[j] * aw[k] - cw[k] * aw[j];
            bxc = bw[j] * cw[k] - bw[k] * cw[j];
            num = cxa * bb + bxc * aa;
            mag = (num < 0) ? -num : num;
            q = mag / denu;
            if (q >= 128'h1_0000_0000) begin
               huge = 1;
               clip = 1;
               cen[i] = (num < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
               d = (num < 0) ? -$signed(q) : $signed(q);
               d = d + p1[i];
               if (d > 128'sd2147483647) begin
                  clip = 1;
                  cen[i] = 32'h7fff_ffff;
               end else if (d < -128'sd2147483648) begin
                  clip = 1;
                  cen[i] = 32'h8000_0000;
               end else begin
                  cen[i] = d[31:0];
               end
               r2 = r2 + q * q;
            end
         end
         if (huge) begin
            root = 64'hffff_ffff;
         end else begin
            root = floor_root(r2);
            if (root > 64'hffff_ffff) begin
               root = 64'hffff_ffff;
               clip = 1;
            end
         end
      end
      o.center_x  = cen[0];
      o.center_y  = cen[1];
      o.center_z  = cen[2];
      o.radius    = root[31:0];
      o.collinear = coll;
      o.clipped   = clip;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit    <= LIMIT_RESET;
         failures = 0;
         wr_count = 0;
         rd_count = 0;
      end else begin
         if (csr_write_enable) limit <= csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (wr_count == rd_count) begin
               $error("response word with nothing expected");
               failures++;
            end else begin
               want = due_mem[rd_count % DUE_DEPTH];
               rd_count++;
               if (rsp_data.center_x !== want.center_x) begin
                  $error("center_x expected %0d got %0d", want.center_x, rsp_data.center_x);
                  failures++;
               end
               if (rsp_data.center_y !== want.center_y) begin
                  $error("center_y expected %0d got %0d", want.center_y, rsp_data.center_y);
                  failures++;
               end
               if (rsp_data.center_z !== want.center_z) begin
                  $error("center_z expected %0d got %0d", want.center_z, rsp_data.center_z);
                  failures++;
               end
               if (rsp_data.radius !== want.radius) begin
                  $error("radius expected %0d got %0d", want.radius, rsp_data.radius);
                  failures++;
               end
               if (rsp_data.collinear !== want.collinear) begin
                  $error("collinear expected %0b got %0b", want.collinear, rsp_data.collinear);
                  failures++;
               end
               if (rsp_data.clipped !== want.clipped) begin
                  $error("clipped expected %0b got %0b", want.clipped, rsp_data.clipped);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_mem[wr_count % DUE_DEPTH] = sphere_of(req_data, limit);
            wr_count++;
         end
      end
   end

   assign outstanding = wr_count - rd_count;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives triangles and limit settings into the circumsphere core with random
// gaps and response stalls; the checker predicts and compares every word
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 100;
   localparam int LONG_HOLD   = 400;

   typedef enum int {SHAPE_FULL, SHAPE_SMALL, SHAPE_LINE, SHAPE_THIN} shape_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;
   logic               csr_write_enable;
   logic [LIMIT_W-1:0] csr_write_data;
   int                 failures;
   int                 outstanding;
   int                 cycles;
   bit                 quiet;
   bit                 hold_request;

   triangle_circumsphere_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   circumsphere_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .failures(failures), .outstanding(outstanding)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("triangle_circumsphere_core test failed");
         $finish;
      end
   end

   // response side stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic req_type triangle(int x1, int y1, int z1, int x2, int y2, int z2,
                                        int x3, int y3, int z3);
      req_type w;
      w = '{x1[15:0], y1[15:0], z1[15:0], x2[15:0], y2[15:0], z2[15:0],
            x3[15:0], y3[15:0], z3[15:0]};
      return w;
   endfunction

   function automatic int near(int base, int spread);
      int v;
      v = base + $signed($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic req_type random_triangle(shape_type shape);
      req_type      w;
      logic [159:0] raw;
      int           x1, y1, z1, x3, y3, z3, t;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[143:0];
      case (shape)
         SHAPE_SMALL: begin
            x1 = near(0, 2000);
            y1 = near(0, 2000);
            z1 = near(0, 2000);
            w = triangle(x1, y1, z1, near(x1, 1500), near(y1, 1500), near(z1, 1500),
                         near(x1, 1500), near(y1, 1500), near(z1, 1500));
         end
         SHAPE_LINE: begin
            x1 = near(0, 16000);
            y1 = near(0, 16000);
            z1 = near(0, 16000);
            x3 = near(x1, 16000);
            y3 = near(y1, 16000);
            z3 = near(z1, 16000);
            t = $urandom_range(0, 4);
            w = triangle(x1, y1, z1, x1 + (x3 - x1) * t / 4, y1 + (y3 - y1) * t / 4,
                         z1 + (z3 - z1) * t / 4, x3, y3, z3);
         end
         SHAPE_THIN: begin
            x1 = near(0, 30000);
            y1 = near(0, 30000);
            z1 = near(0, 30000);
            x3 = near(0, 30000);
            y3 = near(0, 30000);
            z3 = near(0, 30000);
            w = triangle(x1, y1, z1, near((x1 + x3) / 2, 2), near((y1 + y3) / 2, 2),
                         near((z1 + z3) / 2, 2), x3, y3, z3);
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_word(req_type w);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_run(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) send_word(random_triangle(SHAPE_SMALL));
         else if (pick < 5) send_word(random_triangle(SHAPE_LINE));
         else if (pick < 7) send_word(random_triangle(SHAPE_THIN));
         else send_word(random_triangle(SHAPE_FULL));
      end
   endtask

   initial begin
      quiet            = 0;
      hold_request     = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_word(triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(triangle(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767));
      send_word(triangle(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
      send_word(triangle(-32768, 0, 0, 32767, 0, 0, -32768, 32767, 0));
      send_word(triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
      send_word(triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_word(triangle(-1, -1, -1, 0, 0, 0, 1, 1, 1));
      send_word(triangle(-3, 5, -7, -3, 5, -7, 9, -11, 13));
      send_word(triangle(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 1));
      send_word(triangle(-32768, -32768, 0, 32767, 32767, 1, 0, 0, 0));
      send_word(triangle(30000, 30000, 30000, 30000, -30000, 30000, -30000, 30000, -30000));
      write_limit('0);
      send_word(triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_word(triangle(-32768, -32768, 0, 32767, 32767, 1, 0, 0, 0));
      send_word(triangle(-32768, -32768, -32768, 32767, 32767, 32766, 32767, 32767, 32767));
      send_word(triangle(32767, 32767, 0, 32767, 32767, 1, -32768, -32768, 1));
      send_word(triangle(-32768, 32767, -32768, 32767, -32768, 32767, 32767, -32767, 32767));
      write_limit({LIMIT_W{1'b1}});
      send_word(triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
      send_word(triangle(-32768, 0, 0, 32767, 0, 0, -32768, 32767, 0));
      send_word(triangle(-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));

      // random phases through several limit settings
      write_limit(LIMIT_RESET);
      random_run(80);
      write_limit('0);
      random_run(60);
      hold_request = 1;
      random_run(120);
      write_limit({LIMIT_W{1'b1}});
      random_run(40);
      write_limit({8'($urandom_range(0, 255)), $urandom});
      random_run(40);
      wait_idle();
      quiet = 1;
      random_run(60);

      @(negedge clock);
      req_valid = 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN) @(posedge clock);
      if (failures == 0) $display("triangle_circumsphere_core test passed");
      else $display("triangle_circumsphere_core test failed");
      $finish;
   end

endmodule

`default_nettype wire
